>>> rtl/json_syntax_validator_macros.svh
// Assertion macros used by the checker module jsv_checker.
`ifndef JSON_SYNTAX_VALIDATOR_MACROS_SVH
`define JSON_SYNTAX_VALIDATOR_MACROS_SVH

// Check a condition in the same cycle.
`define JSV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("json_syntax_validator: assertion failed");

// Check a condition in the following cycle.
`define JSV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("json_syntax_validator: assertion failed");

`endif

>>> rtl/jsv_pkg.sv
`timescale 1ns / 1ps

package jsv_pkg;

	localparam int STACK_LEVELS = 17;
	localparam int LVL_W        = $clog2(STACK_LEVELS);
	localparam int CNT_W        = $clog2(STACK_LEVELS + 1);
	localparam int DEPTH_W      = 5;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

endpackage

>>> rtl/json_syntax_validator.sv
`timescale 1ns / 1ps

// JSON well-formedness checker.
// Input channel: one document byte per request on text_byte, with is_last set on
// the final byte, qualified by in_valid and held off by in_stall.
// Output channel: one request per document on out_valid, carrying doc_valid
// (1 = well formed), held off by out_stall.
// cfg_wr_en/cfg_wr_data write depth_limit, the deepest level at which a value
// may start; write it only between documents.
// Throughput: one byte per cycle while in_stall is low. Each byte is registered,
// then updates the parse mode, the open-container count and the one-bit kind
// stack as it leaves the input register; the verdict is registered with that update.
// doc_valid is registered from the last byte as it leaves the input register.
// When the receiver stalls, the verdict holds on the output and further bytes
// are still taken; only a following last byte waits in the input register,
// which then raises in_stall until the output is taken.
// Reset: parse state cleared, depth_limit set to 16, both channels empty.
// After each last byte the parse mode and container count return to their reset values.
module json_syntax_validator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [jsv_pkg::DEPTH_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  text_byte,
	input  logic                        is_last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        doc_valid
);
	import jsv_pkg::*;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [11:0] {
		M_VALUE     = 12'b0000_0000_0001,
		M_ARR_FIRST = 12'b0000_0000_0010,
		M_OBJ_FIRST = 12'b0000_0000_0100,
		M_KEY       = 12'b0000_0000_1000,
		M_COLON     = 12'b0000_0001_0000,
		M_AFTER     = 12'b0000_0010_0000,
		M_STR       = 12'b0000_0100_0000,
		M_STR_ESC   = 12'b0000_1000_0000,
		M_KEY_STR   = 12'b0001_0000_0000,
		M_KEY_ESC   = 12'b0010_0000_0000,
		M_SCALAR    = 12'b0100_0000_0000,
		M_ERROR     = 12'b1000_0000_0000
	} mode_t;

	logic [DEPTH_W-1:0]     depth_limit_q;
	mode_t                  mode_q;
	mode_t                  mode_d;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_d;
	logic [CNT_W-1:0]       count_m1;
	logic [STACK_LEVELS-1:0] kind_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   out_valid_q;
	logic                   doc_valid_q;
	logic                   adv;
	logic                   take_in;
	logic                   sp;
	logic                   esc_ok;
	logic                   closer;
	logic                   kind_top;
	mode_t                  sv_mode;
	logic                   sv_push;
	logic                   sv_kind;
	mode_t                  av_mode;
	logic                   av_pop;
	logic                   push;
	logic                   pop;
	logic                   ok;

	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take_in  = in_valid && !in_stall;

	assign sp     = (byte_s1 == CH_SPACE) || (byte_s1 >= CH_TAB && byte_s1 <= CH_CR);
	assign esc_ok = (byte_s1 == CH_QUOTE) || (byte_s1 == CH_BSLASH) || (byte_s1 == CH_SLASH)
		|| (byte_s1 == CH_B) || (byte_s1 == CH_F) || (byte_s1 == CH_N)
		|| (byte_s1 == CH_R) || (byte_s1 == CH_T);
	assign closer = (byte_s1 == CH_COMMA) || (byte_s1 == CH_RBRACK) || (byte_s1 == CH_RBRACE);

	assign count_m1 = count_q - CNT_W'(1);
	assign kind_top = kind_q[count_m1[LVL_W-1:0]];

	always_comb begin
		sv_mode = M_SCALAR;
		sv_push = 1'b0;
		sv_kind = (byte_s1 == CH_LBRACE);
		if (32'(count_q) > 32'(depth_limit_q)) begin
			sv_mode = M_ERROR;
		end else if (byte_s1 == CH_QUOTE) begin
			sv_mode = M_STR;
		end else if (byte_s1 == CH_LBRACK || byte_s1 == CH_LBRACE) begin
			if (32'(count_q) >= STACK_LEVELS) begin
				sv_mode = M_ERROR;
			end else begin
				sv_push = 1'b1;
				sv_mode = sv_kind ? M_OBJ_FIRST : M_ARR_FIRST;
			end
		end else if (closer) begin
			sv_mode = M_ERROR;
		end
	end

	always_comb begin
		av_mode = M_ERROR;
		av_pop  = 1'b0;
		if (count_q == '0) begin
			av_mode = M_ERROR;
		end else if (byte_s1 == CH_COMMA) begin
			av_mode = kind_top ? M_KEY : M_VALUE;
		end else if ((byte_s1 == CH_RBRACK && !kind_top) || (byte_s1 == CH_RBRACE && kind_top)) begin
			av_pop  = 1'b1;
			av_mode = M_AFTER;
		end
	end

	always_comb begin
		mode_d = mode_q;
		push   = 1'b0;
		pop    = 1'b0;
		unique case (mode_q)
			M_VALUE: begin
				if (!sp) begin
					mode_d = sv_mode;
					push   = sv_push;
				end
			end
			M_ARR_FIRST: begin
				if (!sp) begin
					if (byte_s1 == CH_RBRACK) begin
						pop    = 1'b1;
						mode_d = M_AFTER;
					end else begin
						mode_d = sv_mode;
						push   = sv_push;
					end
				end
			end
			M_OBJ_FIRST: begin
				if (!sp) begin
					if (byte_s1 == CH_RBRACE) begin
						pop    = 1'b1;
						mode_d = M_AFTER;
					end else begin
						mode_d = (byte_s1 == CH_QUOTE) ? M_KEY_STR : M_ERROR;
					end
				end
			end
			M_KEY: begin
				if (!sp) mode_d = (byte_s1 == CH_QUOTE) ? M_KEY_STR : M_ERROR;
			end
			M_COLON: begin
				if (!sp) mode_d = (byte_s1 == CH_COLON) ? M_VALUE : M_ERROR;
			end
			M_AFTER: begin
				if (!sp) begin
					mode_d = av_mode;
					pop    = av_pop;
				end
			end
			M_STR: begin
				if (byte_s1 == CH_QUOTE) mode_d = M_AFTER;
				else if (byte_s1 == CH_BSLASH) mode_d = M_STR_ESC;
			end
			M_STR_ESC: begin
				mode_d = esc_ok ? M_STR : M_ERROR;
			end
			M_KEY_STR: begin
				if (byte_s1 == CH_QUOTE) mode_d = M_COLON;
				else if (byte_s1 == CH_BSLASH) mode_d = M_KEY_ESC;
			end
			M_KEY_ESC: begin
				mode_d = esc_ok ? M_KEY_STR : M_ERROR;
			end
			M_SCALAR: begin
				if (sp) begin
					mode_d = M_AFTER;
				end else if (closer) begin
					mode_d = av_mode;
					pop    = av_pop;
				end
			end
			default: begin
				mode_d = M_ERROR;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (push) count_d = count_q + CNT_W'(1);
		else if (pop) count_d = count_m1;
	end

	assign ok = (count_d == '0) && (mode_d == M_AFTER || mode_d == M_SCALAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q <= DEPTH_RESET;
		end else if (cfg_wr_en) begin
			depth_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= text_byte;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_VALUE;
			count_q <= '0;
			kind_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				mode_q  <= M_VALUE;
				count_q <= '0;
			end else begin
				mode_q  <= mode_d;
				count_q <= count_d;
			end
			if (push) kind_q[count_q[LVL_W-1:0]] <= sv_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) doc_valid_q <= ok;
	end

	assign out_valid = out_valid_q;
	assign doc_valid = doc_valid_q;

endmodule

>>> rtl/jsv_checker.sv
`timescale 1ns / 1ps

`include "json_syntax_validator_macros.svh"

module jsv_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic doc_valid
);

	// hold a stalled verdict
	`JSV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(doc_valid))
	// stall input only while the verdict slot is blocked
	`JSV_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall)
	// a held last byte keeps the verdict slot occupied
	`JSV_ASSERT_NEXT(a_in_stall_slot, in_stall, out_valid)

endmodule

bind json_syntax_validator jsv_checker u_jsv_checker (.*);
